// ----- rtl/eyvm_pkg.sv -----
// Shared constants, types and tables for the Y-X-Z view matrix unit.
package eyvm_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int ATAN_ENTRIES  = 24;
    localparam int NSTG = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;

    localparam int ANG_W  = 16;
    localparam int POS_W  = 24;
    localparam int ROT_W  = 16;
    localparam int TRN_W  = 25;
    localparam int CW     = 34;
    localparam int TRIG_W = 22;

    localparam logic signed [CW-1:0] Q30_PI      = 34'sd3373259426;
    localparam logic signed [CW-1:0] Q30_HALF_PI = 34'sd1686629713;
    localparam logic signed [CW-1:0] Q30_GAIN    = 34'sd652032874;

    localparam logic signed [ROT_W-1:0] ROT_LIMIT   = 16'sd16384;
    localparam logic signed [TRN_W-1:0] TRN_LIMIT   = 25'sd14529495;

    localparam int IN_TDATA_W  = 3 * ANG_W + 3 * POS_W;
    localparam int OUT_TDATA_W = 224;

    typedef logic signed [CW-1:0]     cw_t;
    typedef logic signed [TRIG_W-1:0] trig_t;
    typedef logic signed [ROT_W-1:0]  rot_t;

    typedef struct packed {
        trig_t c;
        trig_t s;
    } cs_t;

    function automatic cw_t atan_q30(input int i);
        cw_t t;
        case (i)
            0:  t = 34'sd843314856;
            1:  t = 34'sd497837829;
            2:  t = 34'sd263043836;
            3:  t = 34'sd133525158;
            4:  t = 34'sd67021686;
            5:  t = 34'sd33543515;
            6:  t = 34'sd16775850;
            7:  t = 34'sd8388437;
            8:  t = 34'sd4194282;
            9:  t = 34'sd2097149;
            10: t = 34'sd1048575;
            11: t = 34'sd524287;
            12: t = 34'sd262143;
            13: t = 34'sd131071;
            14: t = 34'sd65535;
            15: t = 34'sd32767;
            16: t = 34'sd16383;
            17: t = 34'sd8191;
            18: t = 34'sd4095;
            19: t = 34'sd2047;
            20: t = 34'sd1023;
            21: t = 34'sd511;
            22: t = 34'sd255;
            default: t = 34'sd127;
        endcase
        return t;
    endfunction

endpackage

// ----- rtl/eyvm_cordic.sv -----
// Pipelined rotation-mode CORDIC giving Q.20 cosine and sine of a Q3.13 angle.
module eyvm_cordic
(
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [eyvm_pkg::ANG_W-1:0]   ang,
    output eyvm_pkg::cs_t                       cs
);

    localparam int N = eyvm_pkg::NSTG;

    eyvm_pkg::cw_t x_reg [N+1];
    eyvm_pkg::cw_t y_reg [N+1];
    eyvm_pkg::cw_t z_reg [N+1];
    logic          neg_reg [N+1];
    eyvm_pkg::cs_t cs_reg;

    eyvm_pkg::cw_t z_next;
    logic          neg_next;
    eyvm_pkg::cw_t xr;
    eyvm_pkg::cw_t yr;

    always_comb
    begin
        z_next   = eyvm_pkg::cw_t'(ang) <<< 17;
        neg_next = 1'b0;
        if (z_next > eyvm_pkg::Q30_HALF_PI)
        begin
            z_next   = z_next - eyvm_pkg::Q30_PI;
            neg_next = 1'b1;
        end
        else if (z_next < -eyvm_pkg::Q30_HALF_PI)
        begin
            z_next   = z_next + eyvm_pkg::Q30_PI;
            neg_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]   <= eyvm_pkg::Q30_GAIN;
            y_reg[0]   <= '0;
            z_reg[0]   <= z_next;
            neg_reg[0] <= neg_next;
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_stage
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                neg_reg[i+1] <= neg_reg[i];
                if (!z_reg[i][eyvm_pkg::CW-1])
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - eyvm_pkg::atan_q30(i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + eyvm_pkg::atan_q30(i);
                end
            end
        end
    end

    always_comb
    begin
        xr = (x_reg[N] + eyvm_pkg::cw_t'(512)) >>> 10;
        yr = (y_reg[N] + eyvm_pkg::cw_t'(512)) >>> 10;
        if (neg_reg[N])
        begin
            xr = -xr;
            yr = -yr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cs_reg.c <= xr[eyvm_pkg::TRIG_W-1:0];
            cs_reg.s <= yr[eyvm_pkg::TRIG_W-1:0];
        end
    end

    assign cs = cs_reg;

endmodule

// ----- rtl/eyvm_matrix.sv -----
// Pipelined products forming the nine rotation entries and three translations.
module eyvm_matrix
(
    input  logic                                clk,
    input  logic                                en,
    input  eyvm_pkg::cs_t                       csx,
    input  eyvm_pkg::cs_t                       csy,
    input  eyvm_pkg::cs_t                       csz,
    input  logic signed [eyvm_pkg::POS_W-1:0]   px,
    input  logic signed [eyvm_pkg::POS_W-1:0]   py,
    input  logic signed [eyvm_pkg::POS_W-1:0]   pz,
    output eyvm_pkg::rot_t                      rot [9],
    output logic signed [eyvm_pkg::TRN_W-1:0]   trn [3]
);

    typedef logic signed [43:0] p2_t;
    typedef logic signed [84:0] p3_t;
    typedef logic signed [40:0] pp_t;

    // stage A: pair products Q.40
    p2_t cycz_reg, sysx_reg, cxsz_reg, cysx_reg, czsy_reg, cysz_reg;
    p2_t cxcz_reg, czsx_reg, sysz_reg, cxsy_reg, cycx_reg;
    logic signed [eyvm_pkg::TRIG_W-1:0] sx_a_reg, sz_a_reg, sx_a2_reg;
    logic signed [eyvm_pkg::POS_W-1:0] pa_reg [3];

    // stage B: Q.60 terms
    p3_t t_reg [12];
    logic signed [eyvm_pkg::TRIG_W-1:0] sx_b_reg;
    logic signed [eyvm_pkg::POS_W-1:0] pb_reg [3];

    // stage C: rounded entries
    eyvm_pkg::rot_t r_reg [9];
    logic signed [eyvm_pkg::POS_W-1:0] pc_reg [3];

    // stage D: position products
    pp_t pp_reg [9];

    // stage E: translations
    logic signed [eyvm_pkg::TRN_W-1:0] tr_reg [3];
    eyvm_pkg::rot_t rd_reg [9];
    eyvm_pkg::rot_t re_reg [9];

    function automatic eyvm_pkg::rot_t ent(input p3_t q);
        p3_t v;
        v = (q + (p3_t'(1) <<< 45)) >>> 46;
        if (v > p3_t'(eyvm_pkg::ROT_LIMIT))
            return eyvm_pkg::ROT_LIMIT;
        if (v < -p3_t'(eyvm_pkg::ROT_LIMIT))
            return -eyvm_pkg::ROT_LIMIT;
        return v[eyvm_pkg::ROT_W-1:0];
    endfunction

    function automatic logic signed [eyvm_pkg::TRN_W-1:0] trs(input pp_t a, input pp_t b,
                                                                input pp_t c);
        logic signed [43:0] v;
        v = -(44'(a) + 44'(b) + 44'(c));
        v = (v + 44'sd8192) >>> 14;
        if (v > 44'(eyvm_pkg::TRN_LIMIT))
            return eyvm_pkg::TRN_LIMIT;
        if (v < -44'(eyvm_pkg::TRN_LIMIT))
            return -eyvm_pkg::TRN_LIMIT;
        return v[eyvm_pkg::TRN_W-1:0];
    endfunction

    localparam p3_t ONE = p3_t'(1) <<< 20;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cycz_reg  <= 44'(csy.c) * 44'(csz.c);
            sysx_reg  <= 44'(csy.s) * 44'(csx.s);
            cxsz_reg  <= 44'(csx.c) * 44'(csz.s);
            cysx_reg  <= 44'(csy.c) * 44'(csx.s);
            czsy_reg  <= 44'(csz.c) * 44'(csy.s);
            cysz_reg  <= 44'(csy.c) * 44'(csz.s);
            cxcz_reg  <= 44'(csx.c) * 44'(csz.c);
            czsx_reg  <= 44'(csz.c) * 44'(csx.s);
            sysz_reg  <= 44'(csy.s) * 44'(csz.s);
            cxsy_reg  <= 44'(csx.c) * 44'(csy.s);
            cycx_reg  <= 44'(csy.c) * 44'(csx.c);
            sx_a_reg  <= csx.s;
            sz_a_reg  <= csz.s;
            sx_a2_reg <= csx.s;
            pa_reg[0] <= px;
            pa_reg[1] <= py;
            pa_reg[2] <= pz;

            t_reg[0]  <= p3_t'(cycz_reg) * ONE;
            t_reg[1]  <= p3_t'(sysx_reg) * p3_t'(sz_a_reg);
            t_reg[2]  <= p3_t'(cxsz_reg) * ONE;
            t_reg[3]  <= p3_t'(cysx_reg) * p3_t'(sz_a_reg);
            t_reg[4]  <= p3_t'(czsy_reg) * ONE;
            t_reg[5]  <= p3_t'(czsy_reg) * p3_t'(sx_a_reg);
            t_reg[6]  <= p3_t'(cysz_reg) * ONE;
            t_reg[7]  <= p3_t'(cxcz_reg) * ONE;
            t_reg[8]  <= p3_t'(cycz_reg) * p3_t'(sx_a2_reg);
            t_reg[9]  <= p3_t'(sysz_reg) * ONE;
            t_reg[10] <= p3_t'(cxsy_reg) * ONE;
            t_reg[11] <= p3_t'(cycx_reg) * ONE;
            sx_b_reg  <= sx_a2_reg;
            pb_reg    <= pa_reg;

            r_reg[0] <= ent(t_reg[0] + t_reg[1]);
            r_reg[1] <= ent(t_reg[2]);
            r_reg[2] <= ent(t_reg[3] - t_reg[4]);
            r_reg[3] <= ent(t_reg[5] - t_reg[6]);
            r_reg[4] <= ent(t_reg[7]);
            r_reg[5] <= ent(t_reg[8] + t_reg[9]);
            r_reg[6] <= ent(t_reg[10]);
            r_reg[7] <= ent(-(p3_t'(sx_b_reg) <<< 40));
            r_reg[8] <= ent(t_reg[11]);
            pc_reg   <= pb_reg;

            for (int k = 0; k < 9; k++)
            begin
                pp_reg[k] <= 41'(r_reg[k]) * 41'(pc_reg[k % 3]);
            end
            rd_reg <= r_reg;

            for (int k = 0; k < 3; k++)
            begin
                tr_reg[k] <= trs(pp_reg[3*k], pp_reg[3*k+1], pp_reg[3*k+2]);
            end
            re_reg <= rd_reg;
        end
    end

    assign rot = re_reg;
    assign trn = tr_reg;

endmodule

// ----- rtl/euler_yxz_view_matrix_unit.sv -----
// Top level of the Y-X-Z view matrix unit: stream ports and pipeline control.
// One pose enters per clock while the output is not stalled, and its result
// passes through the CORDIC (reduction, NSTG iterations, rounding) and then
// the products, rounding and dot products. The whole pipeline advances
// whenever the output register is empty or being taken, so a stall on the
// output holds every stage in place.
module euler_yxz_view_matrix_unit
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // angle_x, angle_y, angle_z, pos_x, pos_y, pos_z
    input  logic [eyvm_pkg::IN_TDATA_W-1:0]       s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // u_x,u_y,u_z,v_x,v_y,v_z,w_x,w_y,w_z, trans_u,trans_v,trans_w, zero pad
    output logic [eyvm_pkg::OUT_TDATA_W-1:0]      m_tdata
);

    localparam int LAT = eyvm_pkg::NSTG + 7;

    logic [LAT-1:0] vld_reg;
    logic           en;
    logic signed [eyvm_pkg::POS_W-1:0] pd_reg [3][eyvm_pkg::NSTG+2];
    eyvm_pkg::cs_t  csx, csy, csz;
    eyvm_pkg::rot_t rot [9];
    logic signed [eyvm_pkg::TRN_W-1:0] trn [3];

    assign en       = !vld_reg[LAT-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
    end

    eyvm_cordic u_cx (.clk(clk), .en(en), .ang(s_tdata[15:0]),  .cs(csx));
    eyvm_cordic u_cy (.clk(clk), .en(en), .ang(s_tdata[31:16]), .cs(csy));
    eyvm_cordic u_cz (.clk(clk), .en(en), .ang(s_tdata[47:32]), .cs(csz));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                pd_reg[k][0] <= s_tdata[48 + 24*k +: 24];
                for (int j = 1; j < eyvm_pkg::NSTG + 2; j++)
                    pd_reg[k][j] <= pd_reg[k][j-1];
            end
        end
    end

    eyvm_matrix u_mat
    (
        .clk(clk), .en(en), .csx(csx), .csy(csy), .csz(csz),
        .px(pd_reg[0][eyvm_pkg::NSTG+1]),
        .py(pd_reg[1][eyvm_pkg::NSTG+1]),
        .pz(pd_reg[2][eyvm_pkg::NSTG+1]),
        .rot(rot), .trn(trn)
    );

    assign m_tdata = {5'd0, trn[2], trn[1], trn[0], rot[8], rot[7], rot[6],
                      rot[5], rot[4], rot[3], rot[2], rot[1], rot[0]};

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the Y-X-Z view matrix unit with a fixed-point pose predictor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [15:0] rot [9];
        logic signed [24:0] trn [3];
    } pose_result_t;

    class view_matrix_board;
        pose_result_t pending [$];
        int           errors;

        function longint asr(longint v, int s);
            return v >>> s;
        endfunction

        function void sin_cos(logic signed [15:0] ang, output longint c, output longint s);
            longint z, x, y, dx, dy;
            bit     neg;
            z = longint'(ang) * (longint'(1) << 17);
            x = longint'(eyvm_pkg::Q30_GAIN);
            y = 0;
            neg = 0;
            if (z > longint'(eyvm_pkg::Q30_HALF_PI))
            begin
                z -= longint'(eyvm_pkg::Q30_PI);
                neg = 1;
            end
            else if (z < -longint'(eyvm_pkg::Q30_HALF_PI))
            begin
                z += longint'(eyvm_pkg::Q30_PI);
                neg = 1;
            end
            for (int i = 0; i < eyvm_pkg::NSTG; i++)
            begin
                dx = asr(y, i);
                dy = asr(x, i);
                if (z >= 0)
                begin
                    x -= dx;
                    y += dy;
                    z -= longint'(eyvm_pkg::atan_q30(i));
                end
                else
                begin
                    x += dx;
                    y -= dy;
                    z += longint'(eyvm_pkg::atan_q30(i));
                end
            end
            x = asr(x + 512, 10);
            y = asr(y + 512, 10);
            c = neg ? -x : x;
            s = neg ? -y : y;
        endfunction

        function longint round_entry(longint v);
            longint r;
            r = asr(v + (longint'(1) << 45), 46);
            if (r > 16384) r = 16384;
            if (r < -16384) r = -16384;
            return r;
        endfunction

        function void note_pose(logic [eyvm_pkg::IN_TDATA_W-1:0] d);
            longint       cx, sx, cy, sy, cz, sz, one, t;
            longint       r [9];
            longint       p [3];
            pose_result_t e;
            one = longint'(1) << 20;
            sin_cos(d[15:0], cx, sx);
            sin_cos(d[31:16], cy, sy);
            sin_cos(d[47:32], cz, sz);
            p[0] = longint'($signed(d[71:48]));
            p[1] = longint'($signed(d[95:72]));
            p[2] = longint'($signed(d[119:96]));
            r[0] = round_entry(cy * cz * one + sy * sx * sz);
            r[1] = round_entry(cx * sz * one);
            r[2] = round_entry(cy * sx * sz - cz * sy * one);
            r[3] = round_entry(cz * sy * sx - cy * sz * one);
            r[4] = round_entry(cx * cz * one);
            r[5] = round_entry(cy * cz * sx + sy * sz * one);
            r[6] = round_entry(cx * sy * one);
            r[7] = round_entry(-sx * one * one);
            r[8] = round_entry(cy * cx * one);
            for (int k = 0; k < 9; k++)
                e.rot[k] = r[k][15:0];
            for (int k = 0; k < 3; k++)
            begin
                t = -(r[3*k] * p[0] + r[3*k+1] * p[1] + r[3*k+2] * p[2]);
                t = asr(t + (longint'(1) << 13), 14);
                if (t > 14529495) t = 14529495;
                if (t < -14529495) t = -14529495;
                e.trn[k] = t[24:0];
            end
            pending.push_back(e);
        endfunction

        function void check_result(logic [eyvm_pkg::OUT_TDATA_W-1:0] d);
            pose_result_t e;
            string        names [12];
            names = '{"u_x", "u_y", "u_z", "v_x", "v_y", "v_z", "w_x", "w_y", "w_z",
                      "trans_u", "trans_v", "trans_w"};
            if (pending.size() == 0)
            begin
                $error("unexpected result transfer");
                errors++;
                return;
            end
            e = pending.pop_front();
            for (int k = 0; k < 9; k++)
                if (d[16*k +: 16] !== e.rot[k])
                begin
                    $error("%s expected %0d actual %0d", names[k], e.rot[k],
                           $signed(d[16*k +: 16]));
                    errors++;
                end
            for (int k = 0; k < 3; k++)
                if (d[144 + 25*k +: 25] !== e.trn[k])
                begin
                    $error("%s expected %0d actual %0d", names[9+k], e.trn[k],
                           $signed(d[144 + 25*k +: 25]));
                    errors++;
                end
        endfunction
    endclass

    logic                                 clk;
    logic                                 rst_n;
    logic                                 s_tvalid;
    logic                                 s_tready;
    logic [eyvm_pkg::IN_TDATA_W-1:0]      s_tdata;
    logic                                 m_tvalid;
    logic                                 m_tready;
    logic [eyvm_pkg::OUT_TDATA_W-1:0]     m_tdata;

    view_matrix_board board;
    int               send_idle_pct;
    int               recv_idle_pct;
    bit               hold_off;
    longint           cycle_count;

    euler_yxz_view_matrix_unit DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    function automatic logic [15:0] rand_angle();
        case ($urandom_range(0, 9))
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 65535));
            default: return 16'($signed($urandom_range(0, 51472)) - 25736);
        endcase
    endfunction

    function automatic logic [23:0] rand_pos();
        case ($urandom_range(0, 5))
            0: return 24'sd0;
            1: return 24'($signed($urandom_range(0, 8192)) - 4096);
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic send_pose(logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                             logic [23:0] px, logic [23:0] py, logic [23:0] pz);
        while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 0;
            @(negedge clk);
        end
        s_tvalid <= 1;
        s_tdata  <= {pz, py, px, az, ay, ax};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        board.note_pose({pz, py, px, az, ay, ax});
        @(negedge clk);
    endtask

    task automatic send_random_poses(int count);
        for (int n = 0; n < count; n++)
            send_pose(rand_angle(), rand_angle(), rand_angle(),
                      rand_pos(), rand_pos(), rand_pos());
    endtask

    // receiver
    initial
    begin
        m_tready = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off)
                m_tready <= 0;
            else
                m_tready <= !(recv_idle_pct > 0 && $urandom_range(0, 99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            board.check_result(m_tdata);

    // long output stall
    initial
    begin
        hold_off = 0;
        @(posedge rst_n);
        repeat (400) @(negedge clk);
        hold_off = 1;
        repeat (150) @(negedge clk);
        hold_off = 0;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > 400000)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin
        board         = new();
        s_tvalid      = 0;
        s_tdata       = '0;
        rst_n         = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        send_pose(16'sd0, 16'sd0, 16'sd0, 24'sd0, 24'sd0, 24'sd0);
        send_pose(16'sd25736, 16'sd25736, 16'sd25736,
                  24'sd8388607, 24'sd8388607, 24'sd8388607);
        send_pose(-16'sd25736, -16'sd25736, -16'sd25736,
                  -24'sd8388608, -24'sd8388608, -24'sd8388608);
        send_pose(16'sh7fff, 16'sh8000, 16'sh7fff, 24'sd8388607, -24'sd8388608, 24'sd4096);
        send_pose(16'sh8000, 16'sh7fff, 16'sh8000, -24'sd8388608, 24'sd8388607, -24'sd4096);
        send_pose(16'sd12868, -16'sd12868, 16'sd12868, 24'sd4096, 24'sd4096, 24'sd4096);
        send_pose(16'sd12869, -16'sd12869, 16'sd12867, -24'sd1, 24'sd1, -24'sd1);
        send_pose(16'sd25736, 16'sd0, -16'sd25736, 24'sd8388607, 24'sd0, -24'sd8388608);
        send_pose(16'sd6434, 16'sd6434, 16'sd0, 24'shffffff, 24'sh555555, 24'shaaaaaa);
        send_pose(16'shffff, 16'sh5555, 16'shaaaa, 24'sh800000, 24'sh7fffff, 24'sh000001);
        send_pose(16'sd1, -16'sd1, 16'sd8192, 24'sd8388607, 24'sd8388607, -24'sd8388608);
        send_pose(-16'sd8192, 16'sd20000, -16'sd20000, -24'sd8388608, 24'sd0, 24'sd8388607);

        send_idle_pct = 31;
        recv_idle_pct = 55;
        send_random_poses(600);
        send_idle_pct = 55;
        recv_idle_pct = 31;
        send_random_poses(550);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random_poses(600);
        s_tvalid <= 0;

        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (board.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
